// File: sv/rtfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtfd_pkg
// shared constants and helper functions of the radiotext frame decoder
// ----------------------------------------------------------------------------
package rtfd_pkg;

    localparam logic [7:0]  START_BYTE   = 8'hFE;
    localparam logic [7:0]  ELEM_RT      = 8'h0A;
    localparam logic [7:0]  MAX_ELEM_LEN = 8'd65;
    localparam logic [7:0]  MIN_ELEM_LEN = 8'd2;
    localparam logic [7:0]  MIN_FRM_LEN  = 8'd4;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  SPACE_CHAR   = 8'h20;

    // one byte of crc-ccitt, byte-wise formulation
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        logic [7:0]  lo;
        x  = {crc[7:0], crc[15:8]} ^ {8'h00, b};
        x  = x ^ {12'h000, x[7:4]};
        lo = x[7:0];
        x  = x ^ {lo[3:0], 12'h000} ^ {3'b000, lo, 5'b00000};
        return x;
    endfunction

    // rds umlaut codes to latin-1, unknown upper codes become space
    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] m;
        if (!c[7]) begin
            m = c;
        end else begin
            unique case (c)
                8'h8D:   m = 8'hDF;
                8'h91:   m = 8'hE4;
                8'hD1:   m = 8'hC4;
                8'h97:   m = 8'hF6;
                8'hD7:   m = 8'hD6;
                8'h99:   m = 8'hFC;
                8'hD9:   m = 8'hDC;
                default: m = SPACE_CHAR;
            endcase
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: sv/rtfd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtfd interfaces
// valid/ready channels for frame bytes in and text items out
// ----------------------------------------------------------------------------
interface rtfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rtfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic [5:0] char_index;
    logic       last;
    logic       crc_ok;

    modport source (output valid, output text_char, output char_index, output last,
                    output crc_ok, input ready);
    modport sink   (input valid, input text_char, input char_index, input last,
                    input crc_ok, output ready);
endinterface
`default_nettype wire

// File: sv/rtfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtfd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rtfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/radiotext_frame_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radiotext_frame_decoder_unit
// uecp radiotext frame parser with crc check and trimmed text output
// ----------------------------------------------------------------------------
// Frame bytes enter on i_in, one per cycle while ready is high. The parser
// hunts for the 0xFE start byte, walks the frame header, requires the
// radiotext element code, checks the element length and writes the mapped
// text characters into a TEXT_DEPTH-entry text RAM. A crc-ccitt covers every
// byte from the one after the start byte to the last text byte. On the low
// crc byte a good frame drains its text from the RAM, trailing spaces trimmed,
// one character per cycle while the output register is free; a bad frame
// gives one item with crc_ok low. Every byte but the last goes straight in; the
// last byte of a good frame holds the input off until all of its (up to 64)
// characters have been loaded into the output register, so the frame end grows
// with the character count, set by the single read port of the text RAM. The
// output register lets new bytes in while the final item still waits. The RAM
// needs no clearing pass: only entries written in the current frame are read.
// ----------------------------------------------------------------------------
module radiotext_frame_decoder_unit
    import rtfd_pkg::*;
#(
    parameter int TEXT_DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtfd_in_if.sink    i_in,
    rtfd_out_if.source o_out
);

    localparam int AW = $clog2(TEXT_DEPTH);

    // frame positions
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_ADDR_HI = 4'd1,
        PH_ADDR_LO = 4'd2,
        PH_SEQ     = 4'd3,
        PH_MFL     = 4'd4,
        PH_MEC     = 4'd5,
        PH_DSN     = 4'd6,
        PH_PSN     = 4'd7,
        PH_MEL     = 4'd8,
        PH_STATUS  = 4'd9,
        PH_TEXT    = 4'd10,
        PH_CRC_HI  = 4'd11,
        PH_CRC_LO  = 4'd12
    } t_phase;

    // accepting bytes, or draining text from the ram
    typedef enum logic {
        S_IN    = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    t_state      r_state,   n_state;
    t_phase      r_phase,   n_phase;
    logic [7:0]  r_frm_len, n_frm_len;
    logic [6:0]  r_rem,     n_rem;
    logic [6:0]  r_wp,      n_wp;
    logic [5:0]  r_last_ns, n_last_ns;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_rx_hi,   n_rx_hi;
    logic [5:0]  r_rd_idx,  n_rd_idx;

    // output register
    logic        r_o_valid, n_o_valid;
    logic [7:0]  r_o_char,  n_o_char;
    logic [5:0]  r_o_idx,   n_o_idx;
    logic        r_o_last,  n_o_last;
    logic        r_o_ok,    n_o_ok;

    // text ram port signals
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_re;
    logic [5:0]    w_rd_idx;
    logic [8:0]    w_rd_ext;
    logic [8:0]    w_wp_ext;
    logic [7:0]    w_rd_data;

    logic        w_in_acc;
    logic        w_out_free;
    logic [7:0]  w_c;
    logic [7:0]  w_map;
    logic        w_len_bad;

    assign w_c        = i_in.data_byte;
    assign w_out_free = !r_o_valid || o_out.ready;
    // the frame end needs the output register, everything else goes straight in
    assign i_in.ready = (r_state == S_IN) && ((r_phase != PH_CRC_LO) || w_out_free);
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_map    = map_char(w_c);
    assign w_wp_ext = {2'b00, r_wp};
    assign w_rd_ext = {3'b000, w_rd_idx};

    // element length checks, frame length guard first so the subtract is safe
    assign w_len_bad = (w_c < MIN_ELEM_LEN) || (w_c > MAX_ELEM_LEN) ||
                       (r_frm_len < MIN_FRM_LEN) ||
                       ({1'b0, w_c} > ({1'b0, r_frm_len} - {1'b0, MIN_FRM_LEN}));

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_frm_len = r_frm_len;
        n_rem     = r_rem;
        n_wp      = r_wp;
        n_last_ns = r_last_ns;
        n_crc     = r_crc;
        n_rx_hi   = r_rx_hi;
        n_rd_idx  = r_rd_idx;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_char  = r_o_char;
        n_o_idx   = r_o_idx;
        n_o_last  = r_o_last;
        n_o_ok    = r_o_ok;
        w_we      = 1'b0;
        w_wr_addr = w_wp_ext[AW-1:0];
        w_wr_data = w_map;
        w_re      = 1'b0;
        w_rd_idx  = r_rd_idx + 6'd1;

        unique case (r_state)
            S_IN: begin
                if (w_in_acc) begin
                    // crc restarts on the first byte after the start byte
                    if (r_phase == PH_ADDR_HI) begin
                        n_crc = crc_step(CRC_INIT, w_c);
                    end else if ((r_phase >= PH_ADDR_LO) && (r_phase <= PH_TEXT)) begin
                        n_crc = crc_step(r_crc, w_c);
                    end

                    unique case (r_phase)
                        PH_HUNT: begin
                            if (w_c == START_BYTE) n_phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: n_phase = PH_ADDR_LO;
                        PH_ADDR_LO: n_phase = PH_SEQ;
                        PH_SEQ:     n_phase = PH_MFL;
                        PH_MFL: begin
                            n_frm_len = w_c;
                            n_phase   = PH_MEC;
                        end
                        PH_MEC:    n_phase = (w_c == ELEM_RT) ? PH_DSN : PH_HUNT;
                        PH_DSN:    n_phase = PH_PSN;
                        PH_PSN:    n_phase = PH_MEL;
                        PH_MEL: begin
                            if (w_len_bad) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_rem     = w_c[6:0] - 7'd2;
                                n_wp      = '0;
                                n_last_ns = '0;
                                n_phase   = PH_STATUS;
                            end
                        end
                        PH_STATUS: n_phase = PH_TEXT;
                        PH_TEXT: begin
                            // characters past the end of a small store are dropped
                            if (w_wp_ext < 9'(TEXT_DEPTH)) begin
                                w_we = 1'b1;
                                if (w_map != SPACE_CHAR) n_last_ns = r_wp[5:0];
                            end
                            n_wp = r_wp + 7'd1;
                            if (r_rem != '0) begin
                                n_rem = r_rem - 7'd1;
                            end else begin
                                n_phase = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI: begin
                            n_rx_hi = w_c;
                            n_phase = PH_CRC_LO;
                        end
                        PH_CRC_LO: begin
                            if ({r_rx_hi, w_c} == ~r_crc) begin
                                // good frame: fetch the first character
                                w_re     = 1'b1;
                                w_rd_idx = '0;
                                n_rd_idx = '0;
                                n_state  = S_DRAIN;
                            end else begin
                                n_o_valid = 1'b1;
                                n_o_char  = '0;
                                n_o_idx   = '0;
                                n_o_last  = 1'b1;
                                n_o_ok    = 1'b0;
                            end
                            n_phase = PH_HUNT;
                        end
                        default: n_phase = (w_c == START_BYTE) ? PH_ADDR_HI : PH_HUNT;
                    endcase
                end
            end
            S_DRAIN: begin
                // ram data holds until the output register takes it
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = w_rd_data;
                    n_o_idx   = r_rd_idx;
                    n_o_last  = (r_rd_idx == r_last_ns);
                    n_o_ok    = 1'b1;
                    if (r_rd_idx == r_last_ns) begin
                        n_state = S_IN;
                    end else begin
                        w_re     = 1'b1;
                        n_rd_idx = r_rd_idx + 6'd1;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_phase   <= PH_HUNT;
            r_frm_len <= '0;
            r_rem     <= '0;
            r_wp      <= '0;
            r_last_ns <= '0;
            r_crc     <= CRC_INIT;
            r_rx_hi   <= '0;
            r_rd_idx  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_frm_len <= n_frm_len;
            r_rem     <= n_rem;
            r_wp      <= n_wp;
            r_last_ns <= n_last_ns;
            r_crc     <= n_crc;
            r_rx_hi   <= n_rx_hi;
            r_rd_idx  <= n_rd_idx;
            r_o_valid <= n_o_valid;
        end
        r_o_char <= n_o_char;
        r_o_idx  <= n_o_idx;
        r_o_last <= n_o_last;
        r_o_ok   <= n_o_ok;
    end

    rtfd_ram #(
        .WIDTH(8),
        .DEPTH(TEXT_DEPTH)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_re      (w_re),
        .i_rd_addr (w_rd_ext[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign o_out.valid      = r_o_valid;
    assign o_out.text_char  = r_o_char;
    assign o_out.char_index = r_o_idx;
    assign o_out.last       = r_o_last;
    assign o_out.crc_ok     = r_o_ok;

endmodule
`default_nettype wire

// File: sv/rtfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtfd_checker
// port-level checks of the radiotext frame decoder
// ----------------------------------------------------------------------------
module rtfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_text_char,
    input wire logic [5:0] i_char_index,
    input wire logic       i_last,
    input wire logic       i_crc_ok
);

    // stalled output item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_text_char) && $stable(i_char_index) &&
            $stable(i_last) && $stable(i_crc_ok))
        else $error("output item changed while stalled");

    // checksum failure is a single empty closing item
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_crc_ok |-> i_last && (i_char_index == 6'd0) &&
            (i_text_char == 8'h00))
        else $error("malformed crc error item");

    // no bytes are taken while a message is still draining
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input taken during text drain");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind radiotext_frame_decoder_unit rtfd_checker u_rtfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_text_char  (o_out.text_char),
    .i_char_index (o_out.char_index),
    .i_last       (o_out.last),
    .i_crc_ok     (o_out.crc_ok)
);
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for radiotext_frame_decoder_unit: feeds uecp frames
// byte by byte, predicts the trimmed text items or the crc error item in a
// scoreboard and compares every output item in order
// ----------------------------------------------------------------------------
module tb_top
    import rtfd_pkg::*;
();

    typedef bit [7:0] t_byte_q[$];

    // ------------------------------------------------------------------------
    // scoreboard: follows the frame parser byte by byte and queues the text
    // items that the block has to produce, then matches them as they arrive
    // ------------------------------------------------------------------------
    class rt_text_tracker;
        typedef enum logic [3:0] {
            POS_HUNT      = 4'd0,
            POS_ADDR_HI   = 4'd1,
            POS_ADDR_LO   = 4'd2,
            POS_SEQ       = 4'd3,
            POS_FRM_LEN   = 4'd4,
            POS_ELEM_CODE = 4'd5,
            POS_DSN       = 4'd6,
            POS_PSN       = 4'd7,
            POS_ELEM_LEN  = 4'd8,
            POS_RT_STATUS = 4'd9,
            POS_TEXT      = 4'd10,
            POS_CRC_HI    = 4'd11,
            POS_CRC_LO    = 4'd12
        } t_frame_pos;

        typedef struct packed {
            logic [7:0] text_char;
            logic [5:0] char_index;
            logic       last;
            logic       crc_ok;
        } t_char_item;

        t_frame_pos  pos;
        logic [7:0]  frame_len;
        logic [6:0]  chars_left;
        logic [6:0]  wr_ptr;
        logic [5:0]  last_nonspace;
        logic [15:0] crc_acc;
        logic [15:0] crc_rx;
        logic [7:0]  text_mem [64];
        t_char_item  due_chars[$];
        int          mismatches;
        int          text_frames;
        int          crc_errors;
        int          chars_checked;

        function new();
            pos           = POS_HUNT;
            frame_len     = '0;
            chars_left    = '0;
            wr_ptr        = '0;
            last_nonspace = '0;
            crc_acc       = CRC_INIT;
            crc_rx        = '0;
            mismatches    = 0;
            text_frames   = 0;
            crc_errors    = 0;
            chars_checked = 0;
        endfunction

        // crc-ccitt, polynomial 0x1021 shifted msb first
        function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            int          i;
            c = crc ^ {b, 8'h00};
            for (i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            end
            return c;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] m;
            int         count;
            int         i;
            if (pos == POS_ADDR_HI) crc_acc = CRC_INIT;
            if (pos >= POS_ADDR_HI && pos <= POS_TEXT) crc_acc = crc_byte(crc_acc, b);

            case (pos)
                POS_HUNT:      if (b == START_BYTE) pos = POS_ADDR_HI;
                POS_ADDR_HI:   pos = POS_ADDR_LO;
                POS_ADDR_LO:   pos = POS_SEQ;
                POS_SEQ:       pos = POS_FRM_LEN;
                POS_FRM_LEN: begin
                    frame_len = b;
                    pos       = POS_ELEM_CODE;
                end
                POS_ELEM_CODE: pos = (b == ELEM_RT) ? POS_DSN : POS_HUNT;
                POS_DSN:       pos = POS_PSN;
                POS_PSN:       pos = POS_ELEM_LEN;
                POS_ELEM_LEN: begin
                    if (b < MIN_ELEM_LEN || b > MAX_ELEM_LEN || frame_len < MIN_FRM_LEN ||
                        int'(b) > int'(frame_len) - 4) begin
                        pos = POS_HUNT;
                    end else begin
                        chars_left    = b[6:0] - 7'd2;
                        wr_ptr        = '0;
                        last_nonspace = '0;
                        pos           = POS_RT_STATUS;
                    end
                end
                POS_RT_STATUS: pos = POS_TEXT;
                POS_TEXT: begin
                    // rds umlauts to latin-1, other upper codes blank out
                    if (b < 8'h80) begin
                        m = b;
                    end else begin
                        case (b)
                            8'h8D:   m = 8'hDF;
                            8'h91:   m = 8'hE4;
                            8'hD1:   m = 8'hC4;
                            8'h97:   m = 8'hF6;
                            8'hD7:   m = 8'hD6;
                            8'h99:   m = 8'hFC;
                            8'hD9:   m = 8'hDC;
                            default: m = SPACE_CHAR;
                        endcase
                    end
                    if (wr_ptr < 7'd64) begin
                        text_mem[wr_ptr[5:0]] = m;
                        if (m != SPACE_CHAR) last_nonspace = wr_ptr[5:0];
                    end
                    wr_ptr = wr_ptr + 7'd1;
                    if (chars_left != 0) chars_left = chars_left - 7'd1;
                    else pos = POS_CRC_HI;
                end
                POS_CRC_HI: begin
                    crc_rx = {b, 8'h00};
                    pos    = POS_CRC_LO;
                end
                POS_CRC_LO: begin
                    crc_rx[7:0] = b;
                    if (crc_rx == ~crc_acc) begin
                        // trailing spaces trimmed, index 0 always sent
                        count = int'(last_nonspace) + 1;
                        for (i = 0; i < count; i++) begin
                            due_chars.push_back(t_char_item'{text_mem[i], 6'(i),
                                                             (i == count - 1), 1'b1});
                        end
                        text_frames++;
                    end else begin
                        due_chars.push_back(t_char_item'{8'h00, 6'd0, 1'b1, 1'b0});
                        crc_errors++;
                    end
                    pos = POS_HUNT;
                end
                default:       pos = (b == START_BYTE) ? POS_ADDR_HI : POS_HUNT;
            endcase
        endfunction

        function void match_char(logic [7:0] ch, logic [5:0] idx, logic lst, logic ok);
            t_char_item want;
            if (due_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected text item char %02h idx %0d last %0b ok %0b",
                             $realtime, ch, idx, lst, ok);
                return;
            end
            want = due_chars.pop_front();
            chars_checked++;
            if (want.text_char !== ch || want.char_index !== idx ||
                want.last !== lst || want.crc_ok !== ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%t: text item mismatch: expected char %02h idx %0d last %0b ok %0b",
                             $realtime, want.text_char, want.char_index, want.last,
                             want.crc_ok);
                    $display("    got char %02h idx %0d last %0b ok %0b", ch, idx, lst, ok);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    rtfd_in_if  in_if();
    rtfd_out_if out_if();

    radiotext_frame_decoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rt_text_tracker sb = new();

    int unsigned src_idle_pct  = 17;
    int unsigned sink_idle_pct = 81;
    int          sent_bytes    = 0;
    t_byte_q     no_text;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // text receiver: ready is redrawn every cycle from the current stall rate
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // every accepted text item goes straight to the scoreboard; values are
    // read right after the edge, so they are the ones the block presented
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.match_char(out_if.text_char, out_if.char_index, out_if.last, out_if.crc_ok);
    end

    // ------------------------------------------------------------------------
    // frame byte driver
    // ------------------------------------------------------------------------
    // one byte on the input channel; random idle cycles go in front of it,
    // valid stays high from one byte to the next when no idle is drawn;
    // the stall pattern flips after a third of the bytes and stops after two
    task automatic send_byte(input bit [7:0] b);
        if (sent_bytes >= 287) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end else if (sent_bytes >= 143) begin
            src_idle_pct  = 81;
            sink_idle_pct = 17;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.take_byte(b);
        sent_bytes++;
    endtask

    // one uecp frame; a foreign element code ends it after the code byte, an
    // empty text ends it after the element length byte (length rejects),
    // otherwise status, text and the inverted crc follow, xored with crc_flip
    task automatic send_frame(input t_byte_q chars, input bit [7:0] elem_code,
                              input bit [7:0] elem_len, input bit [7:0] frm_len,
                              input bit [15:0] crc_flip);
        t_byte_q     q;
        logic [15:0] crc;
        q = '{START_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), frm_len, elem_code};
        if (elem_code == ELEM_RT) begin
            q.push_back(8'($urandom_range(255)));
            q.push_back(8'($urandom_range(255)));
            q.push_back(elem_len);
            if (chars.size() != 0) begin
                q.push_back(8'($urandom_range(255)));
                foreach (chars[i]) q.push_back(chars[i]);
                crc = CRC_INIT;
                for (int i = 1; i < q.size(); i++) crc = sb.crc_byte(crc, q[i]);
                crc = ~crc ^ crc_flip;
                q.push_back(crc[15:8]);
                q.push_back(crc[7:0]);
            end
        end
        foreach (q[i]) begin
            send_byte(q[i]);
        end
    endtask

    // radiotext frame with consistent lengths; pad widens the frame length
    task automatic send_text(input t_byte_q chars, input int pad, input bit [15:0] crc_flip);
        send_frame(chars, ELEM_RT, 8'(chars.size() + 1), 8'(chars.size() + 5 + pad),
                   crc_flip);
    endtask

    // random character mix: printable, spaces, umlauts, other upper codes,
    // control codes and zero
    function automatic bit [7:0] rand_char();
        bit [7:0] umlauts[7] = '{8'h8D, 8'h91, 8'hD1, 8'h97, 8'hD7, 8'h99, 8'hD9};
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(8'h7E, 8'h21));
            4:          return SPACE_CHAR;
            5:          return umlauts[$urandom_range(6)];
            6:          return 8'($urandom_range(8'hFF, 8'h80));
            7:          return 8'($urandom_range(8'h1F, 8'h00));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_byte_q t;
        int      n;
        int      sel;
        int      fl;
        bit [7:0] code;

        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'h00;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames ----------------------------------------------------
        // line noise before the first start byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        // shortest text, frame length exactly at its lower bound
        t = '{8'h41};
        send_text(t, 0, 16'h0000);
        // every umlaut, unmapped upper codes, 0x7f and a zero in the middle
        t = '{8'h8D, 8'h91, 8'hD1, 8'h97, 8'hD7, 8'h99, 8'hD9, 8'h80, 8'hFF, 8'h7F,
              8'h00, 8'h5A};
        send_text(t, 1, 16'h0000);
        // trailing spaces and a trailing unmapped code get trimmed
        t = '{8'h48, 8'h49, 8'h20, 8'h20, 8'hA5, 8'h20};
        send_text(t, 2, 16'h0000);
        // all spaces still gives the character at index 0
        t = '{8'h20, 8'h20, 8'h20};
        send_text(t, 0, 16'h0000);
        // zero character at the end is kept
        t = '{8'h52, 8'h00};
        send_text(t, 0, 16'h0000);
        // longest text, 64 characters
        t = {};
        for (int i = 0; i < 64; i++) t.push_back(8'(8'h21 + i));
        send_text(t, 0, 16'h0000);
        // checksum mismatch in the low and the high crc byte
        t = '{8'h4F, 8'h4B};
        send_text(t, 0, 16'h0001);
        send_text(t, 3, 16'h8000);
        // foreign element codes
        send_frame(no_text, 8'h0B, 8'd0, 8'd0, 16'h0000);
        send_frame(no_text, 8'h00, 8'd0, 8'd0, 16'h0000);
        // element length zero, one, above 65, short frame, length over frame
        send_frame(no_text, ELEM_RT, 8'd0, 8'd20, 16'h0000);
        send_frame(no_text, ELEM_RT, 8'd1, 8'd20, 16'h0000);
        send_frame(no_text, ELEM_RT, 8'd66, 8'd255, 16'h0000);
        send_frame(no_text, ELEM_RT, 8'd2, 8'd3, 16'h0000);
        send_frame(no_text, ELEM_RT, 8'd7, 8'd10, 16'h0000);
        // parser back in step after the rejects
        t = '{8'h4F, 8'h4B};
        send_text(t, 0, 16'h0000);

        // random frames ------------------------------------------------------
        // mostly good frames with random text, some broken ones and noise
        while (sent_bytes < 430) begin
            sel = $urandom_range(99);
            if (sel < 76) begin
                // good or crc-corrupted text; few long texts
                n = ($urandom_range(11) == 0) ? $urandom_range(64, 40) : $urandom_range(12, 1);
                t = {};
                for (int i = 0; i < n; i++) t.push_back(rand_char());
                if ($urandom_range(3) == 0)
                    while (t.size() < 64 && $urandom_range(2) != 0) t.push_back(SPACE_CHAR);
                send_text(t, $urandom_range(3),
                          (sel < 68) ? 16'h0000 : (16'h0001 << $urandom_range(15)));
            end else if (sel < 82) begin
                code = 8'($urandom_range(255));
                if (code == ELEM_RT) code = code ^ 8'h01;
                send_frame(no_text, code, 8'd0, 8'd0, 16'h0000);
            end else if (sel < 89) begin
                case ($urandom_range(3))
                    0: send_frame(no_text, ELEM_RT, 8'($urandom_range(1)), 8'd255,
                                  16'h0000);
                    1: send_frame(no_text, ELEM_RT, 8'($urandom_range(255, 66)), 8'd255,
                                  16'h0000);
                    2: send_frame(no_text, ELEM_RT, 8'($urandom_range(65, 2)),
                                  8'($urandom_range(3)), 16'h0000);
                    default: begin
                        fl = $urandom_range(69, 6);
                        send_frame(no_text, ELEM_RT, 8'(fl - 3), 8'(fl), 16'h0000);
                    end
                endcase
            end else begin
                // noise between frames
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
            end
        end
        in_if.valid <= 1'b0;

        // drain: all predicted items, then room for a full 64-character burst
        while (sb.due_chars.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("covered %0d good text frames and %0d crc error frames in %0d bytes",
                 sb.text_frames, sb.crc_errors, sent_bytes);
        $display("%0d text items checked, %0d mismatches", sb.chars_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.due_chars.size() == 0) begin
            $display("radiotext_frame_decoder_unit regression: pass");
        end else begin
            $display("radiotext_frame_decoder_unit regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("watchdog expired with %0d text items outstanding", sb.due_chars.size());
        $display("radiotext_frame_decoder_unit regression: fail");
        $finish;
    end

endmodule

// File: radiotext_frame_decoder_unit.f
sv/rtfd_pkg.sv
sv/rtfd_if.sv
sv/rtfd_ram.sv
sv/radiotext_frame_decoder_unit.sv
sv/rtfd_checker.sv
bench/tb_top.sv
